// File: hw/rtl/bucket_queue_by_degree_macros.svh
// Assertion helpers for the bucket queue.
`ifndef BUCKET_QUEUE_BY_DEGREE_MACROS_SVH
`define BUCKET_QUEUE_BY_DEGREE_MACROS_SVH

// Same-cycle implication.
`define BQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bqd_pkg.sv
package bqd_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MOVE   = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DEG_LARGE = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_INDEX     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_RM1,
    S_RM2,
    S_INS,
    S_OUT
  } state_t;

  localparam logic [6:0] MARK_NONE = 7'h7f;

  typedef struct packed {
    logic [6:0] low;
    logic [6:0] high;
  } marks_t;

endpackage

// File: hw/rtl/bucket_queue_by_degree.sv
// Bucket queue of graph nodes keyed by degree.
// Input channel (in_valid / in_stall) carries one operation per transaction:
// insert, remove, move, read member or clear. Each accepted transaction
// yields exactly one result transaction on out_valid / out_stall with the
// status, the member read, the addressed bucket's fill, the lowest and
// highest non-empty bucket (-1 when empty) and the total node count.
// The result register loads after acceptance through S_DEC and S_OUT for
// insert, clear and every rejected or no-op transaction, through S_RD as
// well for a read hit, S_RM1 and S_RM2 for remove and S_RM1, S_RM2 and S_INS
// for a move to another bucket; the dependent reads of the node table, fill
// table and member memory set the path. One operation is in flight at a
// time and the next is accepted only after the result loads.
// Results are registered; a stalled result holds and the block waits with
// the next result until the output register drains.
// Reset (rst_n low, synchronous) empties all buckets at once through
// per-bucket and per-node flags; no clearing pass is needed.
module bucket_queue_by_degree #(
  parameter int NODE_COUNT  = 64,
  parameter int NUM_BUCKETS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_op,
  input  logic [5:0]        in_node,
  input  logic [5:0]        in_degree,
  input  logic [5:0]        in_member_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [5:0]        out_read_node,
  output logic [6:0]        out_bucket_size,
  output logic signed [6:0] out_lowest_bucket,
  output logic signed [6:0] out_highest_bucket,
  output logic [6:0]        out_total_count
);

`include "bucket_queue_by_degree_macros.svh"

  localparam int NW = $clog2(NODE_COUNT);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int FW = NW + 1;
  localparam int MEM_DEPTH = NUM_BUCKETS * (2 ** NW);

  bqd_pkg::state_t state_r, state_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [5:0]  node_r, node_nxt;
  logic [5:0]  deg_r, deg_nxt;
  logic [5:0]  mi_r, mi_nxt;
  logic [BW-1:0] home_r, home_nxt;
  logic [NW-1:0] slot_r, slot_nxt;
  logic [FW-1:0] fill_dg_r, fill_dg_nxt;
  logic [FW-1:0] last_r, last_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [5:0]  res_read_r, res_read_nxt;
  logic [6:0]  res_size_r, res_size_nxt;

  logic [NUM_BUCKETS-1:0] nonempty_r, nonempty_nxt;
  logic [NODE_COUNT-1:0]  present_r, present_nxt;
  logic [FW-1:0]          total_r, total_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [5:0]  out_read_r, out_read_nxt;
  logic [6:0]  out_size_r, out_size_nxt;
  logic [6:0]  out_low_r, out_low_nxt;
  logic [6:0]  out_high_r, out_high_nxt;
  logic [6:0]  out_total_r, out_total_nxt;

  logic                mem_we;
  logic [BW+NW-1:0]    mem_waddr, mem_raddr;
  logic [NW-1:0]       mem_wdata, mem_rdata;
  logic                fill_we;
  logic [BW-1:0]       fill_waddr, fill_raddr;
  logic [FW-1:0]       fill_wdata, fill_rdata;
  logic                nt_we;
  logic [NW-1:0]       nt_waddr, nt_raddr;
  logic [BW+NW-1:0]    nt_wdata, nt_rdata;

  bqd_pkg::marks_t marks;

  bqd_ram #(.WIDTH(NW), .DEPTH(MEM_DEPTH)) u_members (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  bqd_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(fill_raddr), .rdata(fill_rdata)
  );

  bqd_ram #(.WIDTH(BW + NW), .DEPTH(NODE_COUNT)) u_nodes (
    .clk(clk), .we(nt_we), .waddr(nt_waddr), .wdata(nt_wdata),
    .raddr(nt_raddr), .rdata(nt_rdata)
  );

  bqd_bounds #(.NUM_BUCKETS(NUM_BUCKETS)) u_bounds (
    .nonempty(nonempty_r),
    .marks(marks)
  );

  logic          node_ok, deg_ok, present, out_free;
  logic [NW-1:0] nd_idx;
  logic [BW-1:0] dg_idx;
  logic [BW-1:0] rd_home;
  logic [NW-1:0] rd_slot;
  logic [FW-1:0] fill_dg;
  logic [FW-1:0] fill_h_last;

  assign node_ok     = 32'(node_r) < NODE_COUNT;
  assign deg_ok      = 32'(deg_r) < NUM_BUCKETS;
  assign nd_idx      = NW'(node_r);
  assign dg_idx      = BW'(deg_r);
  assign present     = node_ok && present_r[nd_idx];
  assign rd_home     = nt_rdata[BW+NW-1:NW];
  assign rd_slot     = nt_rdata[NW-1:0];
  assign fill_dg     = (deg_ok && nonempty_r[dg_idx]) ? fill_rdata : '0;
  assign fill_h_last = fill_rdata - FW'(1);
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != bqd_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bqd_pkg::S_IDLE: begin
        if (in_valid) state_nxt = bqd_pkg::S_DEC;
      end
      bqd_pkg::S_DEC: begin
        state_nxt = bqd_pkg::S_OUT;
        case (op_r)
          bqd_pkg::OP_READ: begin
            if (deg_ok && (32'(mi_r) < 32'(fill_dg))) state_nxt = bqd_pkg::S_RD;
          end
          bqd_pkg::OP_REMOVE: begin
            if (present) state_nxt = bqd_pkg::S_RM1;
          end
          bqd_pkg::OP_MOVE: begin
            if (present && deg_ok && (rd_home != dg_idx)) state_nxt = bqd_pkg::S_RM1;
          end
          default: state_nxt = bqd_pkg::S_OUT;
        endcase
      end
      bqd_pkg::S_RD:  state_nxt = bqd_pkg::S_OUT;
      bqd_pkg::S_RM1: state_nxt = bqd_pkg::S_RM2;
      bqd_pkg::S_RM2: begin
        state_nxt = (op_r == bqd_pkg::OP_MOVE) ? bqd_pkg::S_INS : bqd_pkg::S_OUT;
      end
      bqd_pkg::S_INS: state_nxt = bqd_pkg::S_OUT;
      bqd_pkg::S_OUT: begin
        if (out_free) state_nxt = bqd_pkg::S_IDLE;
      end
      default: state_nxt = bqd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    node_nxt       = node_r;
    deg_nxt        = deg_r;
    mi_nxt         = mi_r;
    home_nxt       = home_r;
    slot_nxt       = slot_r;
    fill_dg_nxt    = fill_dg_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    res_size_nxt   = res_size_r;
    nonempty_nxt   = nonempty_r;
    present_nxt    = present_r;
    total_nxt      = total_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_size_nxt   = out_size_r;
    out_low_nxt    = out_low_r;
    out_high_nxt   = out_high_r;
    out_total_nxt  = out_total_r;
    mem_we         = 1'b0;
    mem_waddr      = {dg_idx, fill_dg[NW-1:0]};
    mem_wdata      = nd_idx;
    mem_raddr      = {dg_idx, NW'(mi_r)};
    fill_we        = 1'b0;
    fill_waddr     = dg_idx;
    fill_wdata     = fill_dg + FW'(1);
    fill_raddr     = BW'(in_degree);
    nt_we          = 1'b0;
    nt_waddr       = nd_idx;
    nt_wdata       = {dg_idx, fill_dg[NW-1:0]};
    nt_raddr       = NW'(in_node);

    case (state_r)
      bqd_pkg::S_IDLE: begin
        op_nxt   = in_op;
        node_nxt = in_node;
        deg_nxt  = in_degree;
        mi_nxt   = in_member_index;
      end
      bqd_pkg::S_DEC: begin
        res_status_nxt = bqd_pkg::ST_OK;
        res_read_nxt   = '0;
        res_size_nxt   = 7'(fill_dg);
        home_nxt       = rd_home;
        slot_nxt       = rd_slot;
        fill_dg_nxt    = fill_dg;
        fill_raddr     = rd_home;
        case (op_r)
          bqd_pkg::OP_INSERT: begin
            if (!node_ok) begin
              res_status_nxt = bqd_pkg::ST_ABSENT;
            end else if (!deg_ok) begin
              res_status_nxt = bqd_pkg::ST_DEG_LARGE;
            end else if (present_r[nd_idx]) begin
              res_status_nxt = bqd_pkg::ST_DUPLICATE;
            end else begin
              mem_we               = 1'b1;
              nt_we                = 1'b1;
              fill_we              = 1'b1;
              nonempty_nxt[dg_idx] = 1'b1;
              present_nxt[nd_idx]  = 1'b1;
              total_nxt            = total_r + FW'(1);
              res_size_nxt         = 7'(fill_dg + FW'(1));
            end
          end
          bqd_pkg::OP_REMOVE: begin
            if (!present) res_status_nxt = bqd_pkg::ST_ABSENT;
          end
          bqd_pkg::OP_MOVE: begin
            if (!present) begin
              res_status_nxt = bqd_pkg::ST_ABSENT;
            end else if (!deg_ok) begin
              res_status_nxt = bqd_pkg::ST_DEG_LARGE;
            end
          end
          bqd_pkg::OP_READ: begin
            if (!deg_ok) begin
              res_status_nxt = bqd_pkg::ST_DEG_LARGE;
            end else if (32'(mi_r) >= 32'(fill_dg)) begin
              res_status_nxt = bqd_pkg::ST_INDEX;
            end
          end
          bqd_pkg::OP_CLEAR: begin
            nonempty_nxt = '0;
            present_nxt  = '0;
            total_nxt    = '0;
            res_size_nxt = '0;
          end
          default: res_status_nxt = bqd_pkg::ST_OK;
        endcase
      end
      bqd_pkg::S_RD: begin
        res_read_nxt = 6'(mem_rdata);
      end
      bqd_pkg::S_RM1: begin
        last_nxt  = fill_h_last;
        mem_raddr = {home_r, fill_h_last[NW-1:0]};
      end
      bqd_pkg::S_RM2: begin
        mem_we     = 1'b1;
        mem_waddr  = {home_r, slot_r};
        mem_wdata  = mem_rdata;
        nt_we      = 1'b1;
        nt_waddr   = mem_rdata;
        nt_wdata   = {home_r, slot_r};
        fill_we    = 1'b1;
        fill_waddr = home_r;
        fill_wdata = last_r;
        if (last_r == '0) nonempty_nxt[home_r] = 1'b0;
        present_nxt[nd_idx] = 1'b0;
        total_nxt = total_r - FW'(1);
        if (op_r == bqd_pkg::OP_REMOVE) res_size_nxt = 7'(last_r);
      end
      bqd_pkg::S_INS: begin
        mem_we               = 1'b1;
        mem_waddr            = {dg_idx, fill_dg_r[NW-1:0]};
        nt_we                = 1'b1;
        nt_wdata             = {dg_idx, fill_dg_r[NW-1:0]};
        fill_we              = 1'b1;
        fill_wdata           = fill_dg_r + FW'(1);
        nonempty_nxt[dg_idx] = 1'b1;
        present_nxt[nd_idx]  = 1'b1;
        total_nxt            = total_r + FW'(1);
        res_size_nxt         = 7'(fill_dg_r + FW'(1));
      end
      bqd_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_read_nxt   = res_read_r;
          out_size_nxt   = res_size_r;
          out_low_nxt    = marks.low;
          out_high_nxt   = marks.high;
          out_total_nxt  = 7'(total_r);
        end
      end
      default: op_nxt = op_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bqd_pkg::S_IDLE;
      nonempty_r  <= '0;
      present_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      present_r   <= present_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    node_r       <= node_nxt;
    deg_r        <= deg_nxt;
    mi_r         <= mi_nxt;
    home_r       <= home_nxt;
    slot_r       <= slot_nxt;
    fill_dg_r    <= fill_dg_nxt;
    last_r       <= last_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    res_size_r   <= res_size_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_size_r   <= out_size_nxt;
    out_low_r    <= out_low_nxt;
    out_high_r   <= out_high_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_node      = out_read_r;
  assign out_bucket_size    = out_size_r;
  assign out_lowest_bucket  = out_low_r;
  assign out_highest_bucket = out_high_r;
  assign out_total_count    = out_total_r;

  `BQD_ASSERT_NOW(a_total_flags, 1'b1, (total_r == '0) == (nonempty_r == '0), "count vs flags")
  `BQD_ASSERT_NOW(a_total_present, 1'b1, $countones(present_r) == 32'(total_r), "count vs nodes")
  `BQD_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_r == bqd_pkg::S_DEC, "no decode")

endmodule

// File: hw/rtl/bqd_ram.sv
module bqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bqd_bounds.sv
module bqd_bounds #(
  parameter int NUM_BUCKETS = 64
) (
  input  logic [NUM_BUCKETS-1:0] nonempty,
  output bqd_pkg::marks_t        marks
);

  logic [6:0] lo;
  logic [6:0] hi;
  logic       found;

  always_comb begin
    lo    = bqd_pkg::MARK_NONE;
    hi    = bqd_pkg::MARK_NONE;
    found = 1'b0;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (nonempty[i]) begin
        if (!found) begin
          lo = 7'(i);
        end
        found = 1'b1;
        hi    = 7'(i);
      end
    end
  end

  assign marks.low  = lo;
  assign marks.high = hi;

endmodule
